// ===== rtl/core/arpc_pkg.sv =====
// Package for the ARP responder with cache: codes, reset values and shared types.
// Used by arpc_cell, arp_responder_with_cache and arpc_checker.
`default_nettype none
package arpc_pkg;

  localparam int DEF_CACHE_SLOTS = 8;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd42;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  localparam logic [31:0] OWN_IP_RESET  = 32'hC0A8_010A;
  localparam logic [47:0] OWN_MAC_RESET = 48'h0200_0000_0001;
  localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_RECEIVE = 2'd0,
    ACT_RESOLVE = 2'd1,
    ACT_REQUEST = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RES_DONE    = 2'd0,
    RES_PRODUCED = 2'd1,
    RES_ERROR   = 2'd2
  } result_t;

  typedef enum logic [1:0] {
    FOP_NONE    = 2'd0,
    FOP_REQUEST = 2'd1,
    FOP_REPLY   = 2'd2
  } frame_op_t;

  typedef enum logic [1:0] {
    REG_OWN_IP  = 2'd0,
    REG_OWN_MAC = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Control broadcast from the sequencer to every cache cell.
  typedef struct packed {
    logic        clear;
    logic        cmp_en;
    logic        wr_en;
    logic [31:0] key;
    logic [47:0] mac;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/arpc_cell.sv =====
// One cache slot of the ARP cache: holds valid, IP and MAC, compares against the key.
// Depends on arpc_pkg for the control struct; cells are chained by claim and hit.
`default_nettype none
module arpc_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  arpc_pkg::cell_ctrl_t     ctrl,
  input  wire                      claim_in,
  output logic                     claim_out,
  input  wire                      hit_in,
  output logic                     hit_out,
  input  wire  [47:0]              hit_mac_in,
  output logic [47:0]              hit_mac_out
);
  import arpc_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  logic        eq_r;
  logic        eq_nxt;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic        cand;
  logic        take;

  // A slot is a candidate for storing when it is free or already holds the key.
  assign cand        = eq_r | ~valid_r;
  assign take        = ctrl.wr_en & cand & ~claim_in;
  assign claim_out   = claim_in | cand;
  assign hit_out     = hit_in | eq_r;
  assign hit_mac_out = hit_mac_in | (eq_r ? mac_r : '0);

  always_comb begin
    eq_nxt = eq_r;
    if (ctrl.cmp_en) begin
      eq_nxt = valid_r & (ip_r == ctrl.key);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (take) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctrl.clear) begin
      ip_r  <= ctrl.key;
      mac_r <= ctrl.mac;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/arp_responder_with_cache.sv =====
// ARP responder with an IP-to-MAC cache built as a chain of slot cells.
// Each input item is captured on acceptance, compared against the key in every cell in ST_CMP,
// and its result is loaded into the output register as it leaves ST_DONE, where it waits while
// the output stalls; the input stalls until then, so a new item is not taken before the last.
// Reset: identity registers return to their defaults and all slot valid bits clear
// at once; no clearing pass is needed.
`default_nettype none
module arp_responder_with_cache #(
  parameter int CACHE_SLOTS = arpc_pkg::DEF_CACHE_SLOTS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_action,
  input  wire  [15:0] in_received_length,
  input  wire  [15:0] in_arp_operation,
  input  wire  [31:0] in_peer_ip,
  input  wire  [47:0] in_peer_mac,
  input  wire  [31:0] in_asked_ip,
  input  wire  [31:0] in_lookup_ip,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_result_code,
  output logic [1:0]  out_frame_op_code,
  output logic [47:0] out_frame_dest_mac,
  output logic [47:0] out_frame_target_mac,
  output logic [31:0] out_frame_target_ip,
  output logic [47:0] out_found_mac,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [47:0] cfg_data
);
  import arpc_pkg::*;

  state_t      state_r;
  state_t      state_nxt;

  logic [31:0] own_ip_r;
  logic [47:0] own_mac_r;
  logic        cfg_clear;

  action_t     act_r;
  logic        short_r;
  logic        for_us_r;
  logic [31:0] key_r;
  logic [31:0] pip_r;
  logic [47:0] pmac_r;
  logic [31:0] lip_r;

  logic        in_take;
  logic        finish;
  logic        store;

  cell_ctrl_t  ctrl;

  logic                    claim [CACHE_SLOTS+1];
  logic                    hit   [CACHE_SLOTS+1];
  logic [47:0]             hmac  [CACHE_SLOTS+1];

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [1:0]  res_code_nxt;
  logic [1:0]  fop_nxt;
  logic [47:0] dest_nxt;
  logic [47:0] tmac_nxt;
  logic [31:0] tip_nxt;
  logic [47:0] found_nxt;
  logic [1:0]  res_code_r;
  logic [1:0]  fop_r;
  logic [47:0] dest_r;
  logic [47:0] tmac_r;
  logic [31:0] tip_r;
  logic [47:0] found_r;

  // Configuration: always ready, identity writes flush the cache.
  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid &&
                     (cfg_index == REG_OWN_IP || cfg_index == REG_OWN_MAC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= OWN_IP_RESET;
      own_mac_r <= OWN_MAC_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OWN_IP) begin
        own_ip_r <= cfg_data[31:0];
      end else if (cfg_index == REG_OWN_MAC) begin
        own_mac_r <= cfg_data;
      end
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign finish   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign store    = (act_r == ACT_RECEIVE) && !short_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r    <= action_t'(in_action);
      short_r  <= (in_received_length < MIN_FRAME_LEN);
      for_us_r <= (in_arp_operation == ARP_OP_REQUEST) && (in_asked_ip == own_ip_r);
      key_r    <= (in_action == ACT_RESOLVE) ? in_lookup_ip : in_peer_ip;
      pip_r    <= in_peer_ip;
      pmac_r   <= in_peer_mac;
      lip_r    <= in_lookup_ip;
    end
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctrl        = '0;
    ctrl.clear  = cfg_clear;
    ctrl.key    = key_r;
    ctrl.mac    = pmac_r;
    case (state_r)
      ST_CMP:  ctrl.cmp_en = 1'b1;
      ST_DONE: ctrl.wr_en  = finish && store;
      default: ctrl.cmp_en = 1'b0;
    endcase
  end

  assign claim[0] = 1'b0;
  assign hit[0]   = 1'b0;
  assign hmac[0]  = '0;

  for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
    arpc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .claim_in    (claim[g]),
      .claim_out   (claim[g+1]),
      .hit_in      (hit[g]),
      .hit_out     (hit[g+1]),
      .hit_mac_in  (hmac[g]),
      .hit_mac_out (hmac[g+1])
    );
  end

  // Result formation.
  always_comb begin
    res_code_nxt = RES_DONE;
    fop_nxt      = FOP_NONE;
    dest_nxt     = '0;
    tmac_nxt     = '0;
    tip_nxt      = '0;
    found_nxt    = '0;
    case (act_r)
      ACT_RECEIVE: begin
        if (short_r) begin
          res_code_nxt = RES_ERROR;
        end else if (for_us_r) begin
          res_code_nxt = RES_PRODUCED;
          fop_nxt      = FOP_REPLY;
          dest_nxt     = pmac_r;
          tmac_nxt     = pmac_r;
          tip_nxt      = pip_r;
        end
      end
      ACT_RESOLVE: begin
        if (hit[CACHE_SLOTS]) begin
          res_code_nxt = RES_PRODUCED;
          found_nxt    = hmac[CACHE_SLOTS];
        end else begin
          res_code_nxt = RES_ERROR;
        end
      end
      ACT_REQUEST: begin
        res_code_nxt = RES_PRODUCED;
        fop_nxt      = FOP_REQUEST;
        dest_nxt     = BROADCAST_MAC;
        tip_nxt      = lip_r;
      end
      default: res_code_nxt = RES_ERROR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_code_r <= res_code_nxt;
      fop_r      <= fop_nxt;
      dest_r     <= dest_nxt;
      tmac_r     <= tmac_nxt;
      tip_r      <= tip_nxt;
      found_r    <= found_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_code      = res_code_r;
  assign out_frame_op_code    = fop_r;
  assign out_frame_dest_mac   = dest_r;
  assign out_frame_target_mac = tmac_r;
  assign out_frame_target_ip  = tip_r;
  assign out_found_mac        = found_r;

endmodule
`default_nettype wire

// ===== rtl/core/arpc_checker.sv =====
// Port-level checks for the ARP responder with cache, bound to the top level.
// Depends on arpc_pkg for result and opcode names.
`default_nettype none
module arpc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  out_result_code,
  input wire [1:0]  out_frame_op_code,
  input wire [47:0] out_found_mac
);
  import arpc_pkg::*;

  // Only one item is in flight, so a transfer is followed by a stall.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_code))
    else $error("stalled result changed or vanished");

  a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_op_code == FOP_REPLY || out_frame_op_code == FOP_REQUEST)
      |-> out_result_code == RES_PRODUCED)
    else $error("frame produced without produced code");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code == RES_ERROR
      |-> out_frame_op_code == FOP_NONE && out_found_mac == '0)
    else $error("error result carries frame or MAC");

endmodule

bind arp_responder_with_cache arpc_checker u_arpc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_code   (out_result_code),
  .out_frame_op_code (out_frame_op_code),
  .out_found_mac     (out_found_mac)
);
`default_nettype wire
